[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cpc_pkg.sv]
`default_nettype none

package cpc_pkg;

  // Field widths
  localparam int PIXEL_W        = 8;
  localparam int COUNT_W        = 20;
  localparam int FRAME_WIDTH_W  = 10;
  localparam int FRAME_HEIGHT_W = 11;
  localparam int THRESH_W       = 8;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;

  // Register reset values
  localparam int WIDTH_RST  = 320;
  localparam int HEIGHT_RST = 200;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd128;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH        = 2'd0,
    REG_FRAME_HEIGHT       = 2'd1,
    REG_CONTRAST_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Line buffer refetch sequencer
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FETCH_CUR,
    ST_FETCH_NEXT
  } fetch_state_t;

  // Neighborhood of one request, handed to the judge
  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;      // incoming pixel
    logic [PIXEL_W-1:0]  mid;        // row above, this column
    logic [PIXEL_W-1:0]  up;         // two rows above, this column
    logic [PIXEL_W-1:0]  right;      // row above, next column
    logic [PIXEL_W-1:0]  prev_mid;   // row above, previous column
    logic [PIXEL_W-1:0]  prev1;      // previous pixel
    logic [PIXEL_W-1:0]  prev2;      // pixel before that
    logic [THRESH_W-1:0] threshold;
    logic                has_above;
    logic                has_two_above;
    logic                has_left;
    logic                has_left2;
    logic                last_col;
    logic                last_row;
  } cpc_window_t;

  // Absolute difference strictly above threshold
  function automatic logic differs(input logic [PIXEL_W-1:0] a,
                                   input logic [PIXEL_W-1:0] b,
                                   input logic [THRESH_W-1:0] thr);
    logic [PIXEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cpc_if.sv]
`default_nettype none

// Pixel request channel
interface cpc_pixel_if import cpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// Frame count result channel
interface cpc_count_if import cpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] contrast_count;

  modport source (output valid, output contrast_count, input ready);
  modport sink   (input valid, input contrast_count, output ready);
endinterface

`default_nettype wire

[rtl/core/contrast_pixel_counter.sv]
// Latency: the frame count is valid on the cycle after the frame's last pixel is taken.
// Throughput: one pixel per cycle; a frame's last pixel waits only while the previous
// count is still unaccepted. Each line buffer RAM takes one write and at most one read
// per pixel. A frame_width write runs FETCH_CUR then FETCH_NEXT, with pixel ready low.
// Reset (rst, synchronous) clears indexes, count, w0..w2 and output valid, not the buffers.
`default_nettype none
`include "assert_macros.svh"

module contrast_pixel_counter import cpc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  cpc_pixel_if.sink             pixel_in,
  cpc_count_if.source           count_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int COL_LAST_RST = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;
  localparam int ROW_LAST_RST = ((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST) - 1;

  // Configuration, kept as clamped last indexes
  logic [CW-1:0]       col_last;
  logic [RW-1:0]       row_last;
  logic [THRESH_W-1:0] threshold;
  logic [31:0]         cfg_w32;
  logic [31:0]         cfg_h32;
  logic [CW-1:0]       col_last_next;
  logic [RW-1:0]       row_last_next;

  // Position and count
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [COUNT_W-1:0]  running_count;

  // Row-above window and prefetch holding registers
  logic [PIXEL_W-1:0]  a0;
  logic [PIXEL_W-1:0]  a1_reg;
  logic                a1_use_reg;
  logic [PIXEL_W-1:0]  t0_reg;
  logic                t0_use_reg;
  logic [PIXEL_W-1:0]  rf0;
  logic [PIXEL_W-1:0]  rf1;
  logic [PIXEL_W-1:0]  w0;
  logic [PIXEL_W-1:0]  w1;
  logic [PIXEL_W-1:0]  w2;

  // Output register
  logic                out_valid;
  logic [COUNT_W-1:0]  out_count;

  // Sequencer
  fetch_state_t state;
  fetch_state_t state_next;
  logic         run;
  logic         fetch_cur;
  logic         fetch_next;

  // Datapath
  logic               in_ready;
  logic               accept;
  logic [CW-1:0]      c;
  logic [RW-1:0]      r;
  logic               last_col;
  logic               last_row;
  logic               frame_end;
  logic [PIXEL_W-1:0] p;
  logic [PIXEL_W-1:0] mid;
  logic [PIXEL_W-1:0] up;
  logic [PIXEL_W-1:0] right;
  cpc_window_t        win;
  logic [1:0]         nhits;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_sat;

  // RAM ports
  logic               la_re;
  logic [CW-1:0]      la_raddr;
  logic [PIXEL_W-1:0] la_rdata;
  logic               lt_re;
  logic [CW-1:0]      lt_raddr;
  logic [PIXEL_W-1:0] lt_rdata;

  // Clamp incoming size writes to the supported range
  assign cfg_w32 = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
  assign cfg_h32 = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);

  always_comb begin
    if (cfg_w32 == 32'd0) begin
      col_last_next = '0;
    end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
      col_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_next = CW'(cfg_w32 - 32'd1);
    end
    if (cfg_h32 == 32'd0) begin
      row_last_next = '0;
    end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
      row_last_next = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last_next = RW'(cfg_h32 - 32'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= CW'(COL_LAST_RST);
      row_last  <= RW'(ROW_LAST_RST);
      threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:        col_last  <= col_last_next;
        REG_FRAME_HEIGHT:       row_last  <= row_last_next;
        REG_CONTRAST_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state: a width change refetches the window at the clamped column
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:        state_next = ST_RUN;
      ST_FETCH_CUR:  state_next = ST_FETCH_NEXT;
      ST_FETCH_NEXT: state_next = ST_RUN;
      default:       state_next = ST_RUN;
    endcase
    if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
      state_next = ST_FETCH_CUR;
    end
  end

  // Sequencer outputs
  always_comb begin
    run        = 1'b0;
    fetch_cur  = 1'b0;
    fetch_next = 1'b0;
    case (state)
      ST_RUN:        run        = 1'b1;
      ST_FETCH_CUR:  fetch_cur  = 1'b1;
      ST_FETCH_NEXT: fetch_next = 1'b1;
      default:       run        = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Handshake: only a frame's last pixel needs the result register free
  assign in_ready       = run && (!out_valid || count_out.ready || !(last_col && last_row));
  assign pixel_in.ready = in_ready;
  assign accept         = pixel_in.valid && in_ready;

  // Current position, clamped after a size change
  assign c         = (col > col_last) ? col_last : col;
  assign r         = (row > row_last) ? row_last : row;
  assign last_col  = (c == col_last);
  assign last_row  = (r == row_last);
  assign frame_end = accept && last_col && last_row;

  // Neighborhood
  assign p     = pixel_in.pixel_value;
  assign mid   = a0;
  assign up    = t0_use_reg ? t0_reg : lt_rdata;
  assign right = a1_use_reg ? a1_reg : la_rdata;

  always_comb begin
    win.pixel         = p;
    win.mid           = mid;
    win.up            = up;
    win.right         = right;
    win.prev_mid      = w0;
    win.prev1         = w1;
    win.prev2         = w2;
    win.threshold     = threshold;
    win.has_above     = (r != '0);
    win.has_two_above = (r > RW'(1));
    win.has_left      = (c != '0);
    win.has_left2     = (c > CW'(1));
    win.last_col      = last_col;
    win.last_row      = last_row;
  end

  cpc_judge u_judge (
    .win   (win),
    .nhits (nhits)
  );

  // Saturating count
  assign count_sum = {1'b0, running_count} + (COUNT_W + 1)'(nhits);
  assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

  // Line buffer reads: prefetch for the next column, or refetch after a width change
  always_comb begin
    la_re    = fetch_cur || fetch_next || (accept && !last_col);
    lt_re    = fetch_cur || accept;
    la_raddr = c + CW'(2);
    lt_raddr = last_col ? '0 : (c + CW'(1));
    if (fetch_cur) begin
      la_raddr = c;
      lt_raddr = c;
    end else if (fetch_next) begin
      la_raddr = c + CW'(1);
    end
  end

  cpc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (p),
    .re    (la_re),
    .raddr (la_raddr),
    .rdata (la_rdata)
  );

  cpc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (mid),
    .re    (lt_re),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  // Position, count and window control
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      running_count <= '0;
      a1_use_reg    <= 1'b0;
      t0_use_reg    <= 1'b0;
      w0            <= '0;
      w1            <= '0;
      w2            <= '0;
    end else if (fetch_next) begin
      t0_use_reg <= 1'b1;
      a1_use_reg <= 1'b0;
    end else if (accept) begin
      w2 <= w1;
      w1 <= p;
      w0 <= mid;
      if (last_col) begin
        col        <= '0;
        a1_use_reg <= 1'b1;
        // one-pixel rows: the two-above entry is the one written now
        t0_use_reg <= (c == '0);
        if (last_row) begin
          row           <= '0;
          running_count <= '0;
        end else begin
          row           <= r + RW'(1);
          running_count <= count_sat;
        end
      end else begin
        col           <= c + CW'(1);
        row           <= r;
        running_count <= count_sat;
        a1_use_reg    <= 1'b0;
        t0_use_reg    <= 1'b0;
      end
    end
  end

  // Window payload
  always_ff @(posedge clk) begin
    if (fetch_next) begin
      a0     <= la_rdata;
      t0_reg <= lt_rdata;
    end else if (accept) begin
      if (c == '0) begin
        rf0 <= p;
      end
      if (c == CW'(1)) begin
        rf1 <= p;
      end
      if (last_col) begin
        // start of next row comes from the first two pixels of this row
        a0     <= (c == '0) ? p : rf0;
        a1_reg <= (c == CW'(1)) ? p : rf1;
        t0_reg <= mid;
      end else begin
        a0 <= right;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_end) begin
      out_valid <= 1'b1;
    end else if (count_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_count <= count_sat;
    end
  end

  assign count_out.valid          = out_valid;
  assign count_out.contrast_count = out_count;

  // Checks
  `CPC_ASSERT_NEXT(a_frame_end_result, frame_end, count_out.valid, "no result after frame end")
  `CPC_ASSERT_NEXT(a_frame_end_clear, frame_end, running_count == '0, "count not cleared")
  `CPC_ASSERT_NOW(a_no_accept_in_fetch, accept, state == ST_RUN, "pixel taken during refetch")

endmodule

`default_nettype wire

[rtl/core/cpc_ram.sv]
`default_nettype none

module cpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write, one registered read; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/cpc_judge.sv]
`default_nettype none

module cpc_judge import cpc_pkg::*; (
  input  cpc_window_t win,
  output logic [1:0]  nhits
);

  logic hit_above;
  logic hit_last_prev;
  logic hit_last_cur;

  // Pixel of the row above, now that its lower neighbor is present
  assign hit_above = win.has_above &
      (differs(win.mid, win.pixel, win.threshold) |
       (win.has_two_above & differs(win.mid, win.up, win.threshold)) |
       (win.has_left & differs(win.mid, win.prev_mid, win.threshold)) |
       (!win.last_col & differs(win.mid, win.right, win.threshold)));

  // Last row: previous pixel, one column behind
  assign hit_last_prev = win.last_row & win.has_left &
      (differs(win.prev1, win.pixel, win.threshold) |
       (win.has_above & differs(win.prev1, win.prev_mid, win.threshold)) |
       (win.has_left2 & differs(win.prev1, win.prev2, win.threshold)));

  // Last row, last column: the current pixel itself
  assign hit_last_cur = win.last_row & win.last_col &
      ((win.has_above & differs(win.pixel, win.mid, win.threshold)) |
       (win.has_left & differs(win.pixel, win.prev1, win.threshold)));

  assign nhits = {1'b0, hit_above} + {1'b0, hit_last_prev} + {1'b0, hit_last_cur};

endmodule

`default_nettype wire

[verif/contrast_pixel_counter_test.sv]
`default_nettype none

module contrast_pixel_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpc_pkg::*;

  localparam int MAX_W = 512;
  localparam int MAX_H = 1024;
  localparam int unsigned LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 4;
  localparam int PHASE_PIXELS = 100;

  // Pixel texture of a random frame
  typedef enum int {
    TEX_NOISE,
    TEX_SMOOTH,
    TEX_BINARY,
    TEX_SPIKES
  } texture_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cpc_pixel_if pixel_if ();
  cpc_count_if count_if ();

  contrast_pixel_counter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_if),
    .count_out(count_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Traffic bookkeeping
  logic [PIXEL_W-1:0] pixel_q[$];
  logic [COUNT_W-1:0] frame_counts_due[$];
  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int send_idle_pct;
  int stall_pct;
  bit hold_armed;
  bit hold_done;
  int hold_count;
  int mismatches;
  int unsigned cycle_count;

  // Predicted block state
  logic [PIXEL_W-1:0]  above_row[MAX_W];
  logic [PIXEL_W-1:0]  two_above_row[MAX_W];
  logic [PIXEL_W-1:0]  prev_mid;
  logic [PIXEL_W-1:0]  prev_px;
  logic [PIXEL_W-1:0]  prev_px2;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [COUNT_W-1:0]  frame_tally;
  int unsigned         reg_width;
  int unsigned         reg_height;
  logic [THRESH_W-1:0] reg_thresh;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit contrasts(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b);
    int diff;
    diff = int'(a) - int'(b);
    if (diff < 0) diff = -diff;
    return diff > int'(reg_thresh);
  endfunction

  function automatic void tally(bit hit);
    if (hit && frame_tally != COUNT_MAX) frame_tally = frame_tally + 1'b1;
  endfunction

  // Advance the frame state by one accepted pixel; queue the count at frame end
  function automatic void judge_pixel(logic [PIXEL_W-1:0] p);
    int unsigned w, h, c, r;
    logic [PIXEL_W-1:0] mid, up, v;
    bit lc, lr, hit;
    w = clamp_dim(reg_width, MAX_W);
    h = clamp_dim(reg_height, MAX_H);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    lc = (c == w - 1);
    lr = (r == h - 1);
    mid = above_row[c];
    up = two_above_row[c];

    // pixel of the row above, now that its lower neighbor is here
    if (r >= 1) begin
      hit = contrasts(mid, p);
      if (r >= 2 && contrasts(mid, up)) hit = 1'b1;
      if (c >= 1 && contrasts(mid, prev_mid)) hit = 1'b1;
      if (!lc && contrasts(mid, above_row[c + 1])) hit = 1'b1;
      tally(hit);
    end

    // bottom row: previous pixel now, and the corner pixel at once
    if (lr) begin
      if (c >= 1) begin
        v = prev_px;
        hit = contrasts(v, p);
        if (r >= 1 && contrasts(v, prev_mid)) hit = 1'b1;
        if (c >= 2 && contrasts(v, prev_px2)) hit = 1'b1;
        tally(hit);
      end
      if (lc) begin
        hit = 1'b0;
        if (r >= 1 && contrasts(p, mid)) hit = 1'b1;
        if (c >= 1 && contrasts(p, prev_px)) hit = 1'b1;
        tally(hit);
      end
    end

    two_above_row[c] = mid;
    above_row[c] = p;
    prev_px2 = prev_px;
    prev_px = p;
    prev_mid = mid;

    if (lc) begin
      col_pos = 0;
      if (lr) begin
        frame_counts_due.push_back(frame_tally);
        frame_tally = '0;
        row_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pixel driver: offers queued requests, predicts on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      pixel_if.valid <= 1'b0;
    end else begin
      if (pixel_if.valid && pixel_if.ready) begin
        judge_pixel(pixel_if.pixel_value);
        pixels_taken++;
      end
      if (!pixel_if.valid || pixel_if.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_if.valid <= 1'b1;
          pixel_if.pixel_value <= pixel_q.pop_front();
        end else begin
          pixel_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count receiver: random stalls, plus one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      count_if.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      count_if.ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      count_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Count monitor
  always @(posedge clk) begin : count_check
    logic [COUNT_W-1:0] due;
    if (!rst && count_if.valid && count_if.ready) begin
      if (frame_counts_due.size() == 0) begin
        $error("contrast_count: unexpected result, actual %0d", count_if.contrast_count);
        mismatches++;
      end else begin
        due = frame_counts_due.pop_front();
        if (count_if.contrast_count !== due) begin
          $error("contrast_count mismatch: expected %0d, actual %0d",
                 due, count_if.contrast_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic push_pixel(logic [PIXEL_W-1:0] p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  // Every accepted pixel predicted and every count delivered, then settle
  task automatic wait_block_idle();
    while (pixels_taken != pixels_queued || frame_counts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_FRAME_WIDTH:        reg_width = value[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT:       reg_height = value[FRAME_HEIGHT_W-1:0];
      REG_CONTRAST_THRESHOLD: reg_thresh = value[THRESH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned thr);
    wait_block_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CONTRAST_THRESHOLD, thr);
  endtask

  // One whole frame at the current size, random content of the given texture
  task automatic queue_frame(texture_t tex);
    int n, base, spread, v;
    n = clamp_dim(reg_width, MAX_W) * clamp_dim(reg_height, MAX_H);
    base = $urandom_range(255);
    spread = int'(reg_thresh) / 2 + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (tex)
        TEX_NOISE:  v = $urandom_range(255);
        TEX_SMOOTH: v = base + $urandom_range(0, 2 * spread) - spread;
        TEX_BINARY: v = $urandom_range(1) ? 255 : 0;
        default: begin
          if ($urandom_range(15) == 0) base = $urandom_range(255);
          v = ($urandom_range(7) == 0) ? $urandom_range(255) : base;
        end
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      push_pixel(v[PIXEL_W-1:0]);
    end
  endtask

  function automatic int unsigned pick_thresh();
    case ($urandom_range(5))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 16);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    logic [PIXEL_W-1:0] pat[$];
    int unsigned phase_start, w, h;
    int nframes;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    pixel_if.valid = 1'b0;
    pixel_if.pixel_value = '0;
    count_if.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    hold_count = 0;
    mismatches = 0;
    pixels_queued = 0;
    pixels_taken = 0;
    foreach (above_row[i]) begin
      above_row[i] = '0;
      two_above_row[i] = '0;
    end
    prev_mid = '0;
    prev_px = '0;
    prev_px2 = '0;
    col_pos = 0;
    row_pos = 0;
    frame_tally = '0;
    reg_width = WIDTH_RST;
    reg_height = HEIGHT_RST;
    reg_thresh = THRESH_RST;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero width and height act as a single pixel frame
    set_frame(0, 0, 0);
    push_pixel(8'hFF);

    // flat 3x3 with one corner off by one, any difference counts
    set_frame(3, 3, 0);
    pat = '{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11};
    foreach (pat[i]) push_pixel(pat[i]);

    // full-scale checkerboard just above threshold
    set_frame(2, 2, 254);
    pat = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    foreach (pat[i]) push_pixel(pat[i]);

    // single column, top threshold: nothing can count
    set_frame(1, 5, 255);
    pat = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    foreach (pat[i]) push_pixel(pat[i]);

    // single row, difference equal to threshold does not count
    set_frame(5, 1, 128);
    pat = '{8'd0, 8'd128, 8'd129, 8'd0, 8'd255};
    foreach (pat[i]) push_pixel(pat[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase

      // widest row, width above range clamps to the maximum
      if (ph == 0) begin
        set_frame(1023, 1, pick_thresh());
        queue_frame(TEX_NOISE);
      end
      // tall single-column frame, zero width acts as one
      if (ph == 1) begin
        set_frame(0, 120, $urandom_range(0, 40));
        queue_frame(TEX_SMOOTH);
      end
      // long receiver hold-off while frames keep streaming in
      if (ph == 2) begin
        set_frame(5, 4, $urandom_range(0, 60));
        hold_armed = 1'b1;
        repeat (4) queue_frame(TEX_SMOOTH);
      end

      phase_start = pixels_queued;
      while (pixels_queued - phase_start < PHASE_PIXELS) begin
        if ($urandom_range(19) == 0) w = 0;
        else if ($urandom_range(9) == 0) w = $urandom_range(13, 40);
        else w = $urandom_range(1, 12);
        h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
        set_frame(w, h, pick_thresh());
        nframes = $urandom_range(1, 3);
        for (int f = 0; f < nframes; f++) begin
          // sometimes hold the next frame until all counts are back
          if (f > 0 && $urandom_range(3) == 0) wait_block_idle();
          queue_frame(texture_t'($urandom_range(3)));
        end
      end
    end

    wait_block_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
